// ===== sv/swlf_pkg.sv =====
`timescale 1ns / 1ps

package swlf_pkg;

  localparam int unsigned CW = 17;
  localparam logic [CW-1:0] COURANT_RESET = 17'd6554;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = -32'sh7FFF_FFFF - 32'sd1;
  localparam int unsigned DIV_STEPS = 31;

  typedef struct packed {
    logic signed [31:0] phi_in;
    logic signed [31:0] mom_in;
    logic               first_cell;
    logic               last_cell;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] phi_out;
    logic signed [31:0] mom_out;
    logic               row_end;
    logic               bad_depth;
    logic               saturated;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } lf_res_t;

  // ((aL+aR)*2^16 - c*(bR-bL) + 2^16) >> 17, floor, then clip to 32 bits
  function automatic lf_res_t lf_round(input logic signed [32:0] asum,
                                       input logic signed [65:0] cprod);
    logic signed [67:0] x;
    logic signed [50:0] r;
    lf_res_t res;
    x = (68'(asum) <<< 16) - 68'(cprod) + 68'sd65536;
    r = 51'(x >>> 17);
    if (r > 51'(Q_MAX)) begin
      res.value = Q_MAX;
      res.clip  = 1'b1;
    end else if (r < 51'(Q_MIN)) begin
      res.value = Q_MIN;
      res.clip  = 1'b1;
    end else begin
      res.value = r[31:0];
      res.clip  = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== sv/shallow_water_lax_friedrichs_row.sv =====
`timescale 1ns / 1ps

// One Lax-Friedrichs row step for 1-D shallow water, fed left to right one cell per input
// beat and giving the new row one cell behind; boundary cells are copied. While a beat is
// worked on, in_ready is low. It passes through the shared 33x33 multiplier for m*m and
// phi*phi, a set-up step and 31 steps of a radix-2 restoring divider for m*m/phi, the flux,
// the window shift and a return to idle. Each result beat adds an emit state and an inner
// cell adds multiplier and rounding steps for the two updates. A non-positive phi or an
// overflowing quotient skips the divider. Results leave through an output register, so the
// last result may wait while the next cell is worked on; a result still held there stalls
// the next emit. The user must write courant through courant_we/courant_data only while
// the block is idle; the block itself does not enforce it.
module shallow_water_lax_friedrichs_row import swlf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              courant_we,
  input  logic [CW-1:0]     courant_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_beat_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_beat_t         out_data
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_MM, ST_MUL_PP, ST_DIV_INIT, ST_DIV, ST_FLUX,
    ST_UPD_P, ST_UPD_M, ST_UPD_N, ST_FINISH, ST_EMIT1, ST_EMIT2
  } state_t;

  state_t             state;
  logic [CW-1:0]      courant;

  logic signed [31:0] cur_phi, cur_mom;
  logic               cur_first, cur_last;
  logic signed [31:0] cur_flux;
  logic               cur_fsat;

  logic signed [31:0] phi_prev1, mom_prev1, flux_prev1;
  logic signed [31:0] phi_prev2, mom_prev2, flux_prev2;
  logic               fsat_prev1, fsat_prev2;
  logic [1:0]         cells_seen;

  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;
  logic [62:0]        mm;
  logic [45:0]        psq;
  logic [30:0]        rem, dlo, quo;
  logic               qovf;
  logic [4:0]         cnt;

  lf_res_t            np, nm;
  out_beat_t          res1, res2;
  logic [1:0]         nres;

  logic [31:0]        rem_sh;
  logic               div_ge;
  logic [46:0]        fsum;
  logic               fclip;
  logic               row_open;
  lf_res_t            lf_now;

  always_comb begin
    mul_a = 33'(cur_mom);
    mul_b = 33'(cur_mom);
    unique case (state)
      ST_MUL_PP: begin
        mul_a = 33'(cur_phi);
        mul_b = 33'(cur_phi);
      end
      ST_UPD_P: begin
        mul_a = $signed({16'd0, courant});
        mul_b = 33'(cur_mom) - 33'(mom_prev2);
      end
      ST_UPD_M: begin
        mul_a = $signed({16'd0, courant});
        mul_b = 33'(cur_flux) - 33'(flux_prev2);
      end
      default: begin
        mul_a = 33'(cur_mom);
        mul_b = 33'(cur_mom);
      end
    endcase
  end

  assign rem_sh   = {1'b0, rem} << 1 | 32'(dlo[30]);
  assign div_ge   = rem_sh >= $unsigned(cur_phi);
  assign fsum     = 47'(quo) + 47'(psq);
  assign fclip    = qovf || (fsum > 47'(Q_MAX));
  assign row_open = !(cur_first || (cells_seen == 2'd0));
  assign lf_now   = (state == ST_UPD_M)
                    ? lf_round(33'(phi_prev2) + 33'(cur_phi), prod)
                    : lf_round(33'(mom_prev2) + 33'(cur_mom), prod);
  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      courant    <= COURANT_RESET;
      cells_seen <= 2'd0;
      out_valid  <= 1'b0;
      phi_prev1  <= '0;
      mom_prev1  <= '0;
      flux_prev1 <= '0;
      phi_prev2  <= '0;
      mom_prev2  <= '0;
      flux_prev2 <= '0;
      fsat_prev1 <= 1'b0;
      fsat_prev2 <= 1'b0;
    end else begin
      if (courant_we) begin
        courant <= courant_data;
      end
      if (out_valid && out_ready && state != ST_EMIT1 && state != ST_EMIT2) begin
        out_valid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur_phi   <= in_data.phi_in;
            cur_mom   <= in_data.mom_in;
            cur_first <= in_data.first_cell;
            cur_last  <= in_data.last_cell;
            state     <= ST_MUL_MM;
          end
        end
        ST_MUL_MM: begin
          state <= ST_MUL_PP;
        end
        ST_MUL_PP: begin
          mm    <= prod[62:0];
          state <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          psq <= prod[62:17];
          quo <= '0;
          if (cur_phi <= 32'sd0) begin
            qovf  <= 1'b0;
            state <= ST_FLUX;
          end else if (mm[62:31] >= $unsigned(cur_phi)) begin
            qovf  <= 1'b1;
            state <= ST_FLUX;
          end else begin
            qovf  <= 1'b0;
            rem   <= mm[61:31];
            dlo   <= mm[30:0];
            cnt   <= 5'(DIV_STEPS - 1);
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem <= div_ge ? 31'(rem_sh - $unsigned(cur_phi)) : rem_sh[30:0];
          quo <= {quo[29:0], div_ge};
          dlo <= dlo << 1;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            state <= ST_FLUX;
          end
        end
        ST_FLUX: begin
          cur_fsat <= fclip;
          cur_flux <= fclip ? Q_MAX : $signed(fsum[31:0]);
          state    <= (row_open && cells_seen == 2'd2) ? ST_UPD_P : ST_FINISH;
        end
        ST_UPD_P: begin
          state <= ST_UPD_M;
        end
        ST_UPD_M: begin
          np    <= lf_now;
          state <= ST_UPD_N;
        end
        ST_UPD_N: begin
          nm    <= lf_now;
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          res2.phi_out   <= cur_phi;
          res2.mom_out   <= cur_mom;
          res2.row_end   <= 1'b1;
          res2.bad_depth <= 1'b0;
          res2.saturated <= 1'b0;
          if (!row_open) begin
            res1.phi_out   <= cur_phi;
            res1.mom_out   <= cur_mom;
            res1.row_end   <= 1'b1;
            res1.bad_depth <= 1'b0;
            res1.saturated <= 1'b0;
            nres           <= cur_last ? 2'd1 : 2'd0;
            cells_seen     <= cur_last ? 2'd0 : 2'd1;
          end else begin
            if (cells_seen == 2'd1) begin
              res1.phi_out   <= phi_prev1;
              res1.mom_out   <= mom_prev1;
              res1.bad_depth <= 1'b0;
              res1.saturated <= 1'b0;
            end else begin
              res1.phi_out   <= np.value;
              res1.mom_out   <= nm.value;
              res1.bad_depth <= (phi_prev2 <= 32'sd0) || (cur_phi <= 32'sd0);
              res1.saturated <= fsat_prev2 || cur_fsat || np.clip || nm.clip;
            end
            res1.row_end <= 1'b0;
            nres         <= cur_last ? 2'd2 : 2'd1;
            cells_seen   <= cur_last ? 2'd0 : 2'd2;
          end
          phi_prev2  <= phi_prev1;
          mom_prev2  <= mom_prev1;
          flux_prev2 <= flux_prev1;
          fsat_prev2 <= fsat_prev1;
          phi_prev1  <= cur_phi;
          mom_prev1  <= cur_mom;
          flux_prev1 <= cur_flux;
          fsat_prev1 <= cur_fsat;
          state      <= (row_open || cur_last) ? ST_EMIT1 : ST_IDLE;
        end
        ST_EMIT1: begin
          if (!out_valid || out_ready) begin
            out_data  <= res1;
            out_valid <= 1'b1;
            state     <= (nres == 2'd2) ? ST_EMIT2 : ST_IDLE;
          end
        end
        ST_EMIT2: begin
          if (!out_valid || out_ready) begin
            out_data  <= res2;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== test/tb_shallow_water_lax_friedrichs_row.sv =====
`timescale 1ns / 1ps

module tb_shallow_water_lax_friedrichs_row;
  import swlf_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE = 80;
  localparam int PHASE_CELLS = 200;
  localparam logic [31:0] ZERO = 32'h0000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] TWO = 32'h0002_0000;
  localparam logic [31:0] THREE = 32'h0003_0000;
  localparam logic [31:0] FIVE = 32'h0005_0000;
  localparam logic [31:0] NEG_ONE = 32'hFFFF_0000;
  localparam out_beat_t NO_RES = '0;

  typedef struct {
    in_beat_t  stim;
    int        n_fixed;  // -1: left to the predictor
    out_beat_t r0;
    out_beat_t r1;
  } dir_row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          courant_we = 1'b0;
  logic [CW-1:0] courant_data = COURANT_RESET;
  logic          in_valid = 1'b0;
  logic          in_ready;
  in_beat_t      in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  out_beat_t     out_data;

  // predictor state: near is the newest held cell, far the one before it
  logic [CW-1:0] courant_q = COURANT_RESET;
  longint        near_phi = 0, near_mom = 0, near_flux = 0;
  longint        far_phi = 0, far_mom = 0, far_flux = 0;
  bit            near_fsat = 1'b0, far_fsat = 1'b0;
  int            held = 0;

  out_beat_t     fresh[$];
  out_beat_t     due_cells[$];
  int            errors = 0;
  int            cycles = 0;
  int            send_idle = 0;
  int            recv_stall = 0;
  logic          hold_req = 1'b0;
  bit            hold_taken = 1'b0;
  int            hold_cnt = 0;
  dir_row_t      dir_tab[21];

  always #10 clk = ~clk;

  shallow_water_lax_friedrichs_row u_dut (
    .clk          (clk),
    .rst          (rst),
    .courant_we   (courant_we),
    .courant_data (courant_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  function automatic in_beat_t cell_of(logic [31:0] p, logic [31:0] m, logic f, logic l);
    in_beat_t c;
    c.phi_in = p;
    c.mom_in = m;
    c.first_cell = f;
    c.last_cell = l;
    return c;
  endfunction

  function automatic out_beat_t res_beat(logic [31:0] p, logic [31:0] m, logic e, logic b,
                                         logic s);
    out_beat_t r;
    r.phi_out = p;
    r.mom_out = m;
    r.row_end = e;
    r.bad_depth = b;
    r.saturated = s;
    return r;
  endfunction

  // m*m/phi + phi*phi/2, clipped at the top
  function automatic longint flux_of(longint p, longint m, output bit sat);
    longint s;
    s = (p * p) >>> 17;
    if (p > 0) s += (m * m) / p;
    sat = s > longint'(Q_MAX);
    if (sat) s = longint'(Q_MAX);
    return s;
  endfunction

  function automatic longint lf_blend(longint a_l, longint a_r, longint b_l, longint b_r,
                                      inout bit sat);
    longint x;
    longint r;
    x = (a_l + a_r) * 65536 - longint'(courant_q) * (b_r - b_l) + 65536;
    r = x >>> 17;
    if (r > longint'(Q_MAX)) begin
      r = longint'(Q_MAX);
      sat = 1'b1;
    end
    if (r < longint'(Q_MIN)) begin
      r = longint'(Q_MIN);
      sat = 1'b1;
    end
    return r;
  endfunction

  task automatic advance_row(input in_beat_t c);
    longint p, m, f, np, nm;
    bit fs, bad, sat;
    p = longint'(c.phi_in);
    m = longint'(c.mom_in);
    f = flux_of(p, m, fs);
    if (c.first_cell || held == 0) begin
      if (c.last_cell) begin
        fresh.push_back(res_beat(c.phi_in, c.mom_in, 1'b1, 1'b0, 1'b0));
        held = 0;
      end else begin
        held = 1;
      end
    end else begin
      if (held == 1) begin
        fresh.push_back(res_beat(near_phi[31:0], near_mom[31:0], 1'b0, 1'b0, 1'b0));
      end else begin
        bad = (far_phi <= 0) || (p <= 0);
        sat = far_fsat || fs;
        np = lf_blend(far_phi, p, far_mom, m, sat);
        nm = lf_blend(far_mom, m, far_flux, f, sat);
        fresh.push_back(res_beat(np[31:0], nm[31:0], 1'b0, bad, sat));
      end
      if (c.last_cell) begin
        fresh.push_back(res_beat(c.phi_in, c.mom_in, 1'b1, 1'b0, 1'b0));
        held = 0;
      end else begin
        held = 2;
      end
    end
    far_phi = near_phi;
    far_mom = near_mom;
    far_flux = near_flux;
    far_fsat = near_fsat;
    near_phi = p;
    near_mom = m;
    near_flux = f;
    near_fsat = fs;
  endtask

  task automatic offer(input in_beat_t c, input int n_fixed, input out_beat_t r0,
                       input out_beat_t r1);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    fresh.delete();
    advance_row(c);
    if (n_fixed < 0) begin
      foreach (fresh[i]) due_cells.push_back(fresh[i]);
    end else begin
      if (n_fixed > 0) due_cells.push_back(r0);
      if (n_fixed > 1) due_cells.push_back(r1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_courant(input logic [CW-1:0] v);
    drain();
    courant_we <= 1'b1;
    courant_data <= v;
    @(posedge clk);
    courant_we <= 1'b0;
    courant_q = v;
  endtask

  function automatic logic [31:0] rand_q(bit for_phi);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 6) begin
      case ($urandom_range(4))
        0: return Q_MAX;
        1: return Q_MIN;
        2: return 32'h0;
        3: return 32'h1;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    if (sel < 16) return $urandom();
    if (for_phi && sel < 20) return -$urandom_range(1, 32'h0004_0000);
    if (for_phi) return $urandom_range(32'h0000_4000, 32'h0040_0000);
    return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
  endfunction

  // well-formed row with random content; a few rows open without the first flag
  // and a few cells carry random flags
  task automatic send_row(input int len);
    in_beat_t c;
    bit opened;
    opened = ($urandom_range(19) != 0);
    for (int i = 0; i < len; i++) begin
      c = cell_of(rand_q(1'b1), rand_q(1'b0), (i == 0) && opened, i == len - 1);
      if ($urandom_range(99) < 6) begin
        c.first_cell = 1'($urandom_range(1));
        c.last_cell = 1'($urandom_range(1));
      end
      offer(c, -1, NO_RES, NO_RES);
    end
  endtask

  task automatic check_beat(input out_beat_t got);
    out_beat_t want;
    if (due_cells.size() == 0) begin
      $display("%0t: unexpected beat phi %h mom %h end %b bad %b sat %b", $time,
               got.phi_out, got.mom_out, got.row_end, got.bad_depth, got.saturated);
      errors++;
    end else begin
      want = due_cells.pop_front();
      if (got.phi_out !== want.phi_out || got.mom_out !== want.mom_out ||
          got.row_end !== want.row_end || got.bad_depth !== want.bad_depth ||
          got.saturated !== want.saturated) begin
        $display("%0t: expected phi %h mom %h end %b bad %b sat %b", $time,
                 want.phi_out, want.mom_out, want.row_end, want.bad_depth, want.saturated);
        $display("%0t:   actual phi %h mom %h end %b bad %b sat %b", $time,
                 got.phi_out, got.mom_out, got.row_end, got.bad_depth, got.saturated);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_beat(out_data);
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int left;
    int len;
    logic [CW-1:0] cour_tab[5];
    int idle_tab[5];
    int stall_tab[5];
    cour_tab = '{COURANT_RESET, 17'd0, 17'd65536, 17'd0, 17'h1FFFF};
    idle_tab = '{0, 83, 0, 34, 0};
    stall_tab = '{0, 0, 83, 34, 0};
    dir_tab = '{
      '{cell_of(Q_MAX, Q_MIN, 1'b1, 1'b1), 1,
        res_beat(Q_MAX, Q_MIN, 1'b1, 1'b0, 1'b0), NO_RES},
      '{cell_of(Q_MIN, Q_MAX, 1'b1, 1'b1), 1,
        res_beat(Q_MIN, Q_MAX, 1'b1, 1'b0, 1'b0), NO_RES},
      '{cell_of(ONE, ZERO, 1'b1, 1'b0), 0, NO_RES, NO_RES},
      '{cell_of(TWO, NEG_ONE, 1'b0, 1'b1), 2, res_beat(ONE, ZERO, 1'b0, 1'b0, 1'b0),
        res_beat(TWO, NEG_ONE, 1'b1, 1'b0, 1'b0)},
      '{cell_of(ONE, ZERO, 1'b1, 1'b0), 0, NO_RES, NO_RES},
      '{cell_of(THREE, FIVE, 1'b0, 1'b0), 1, res_beat(ONE, ZERO, 1'b0, 1'b0, 1'b0), NO_RES},
      '{cell_of(ONE, ZERO, 1'b0, 1'b1), 2, res_beat(ONE, ZERO, 1'b0, 1'b0, 1'b0),
        res_beat(ONE, ZERO, 1'b1, 1'b0, 1'b0)},
      // dry neighbours: bad depth
      '{cell_of(ZERO, ZERO, 1'b1, 1'b0), 0, NO_RES, NO_RES},
      '{cell_of(ONE, Q_MAX, 1'b0, 1'b0), 1, res_beat(ZERO, ZERO, 1'b0, 1'b0, 1'b0), NO_RES},
      '{cell_of(ZERO, ZERO, 1'b0, 1'b1), 2, res_beat(ZERO, ZERO, 1'b0, 1'b1, 1'b0),
        res_beat(ZERO, ZERO, 1'b1, 1'b0, 1'b0)},
      '{cell_of(NEG_ONE, TWO, 1'b1, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(Q_MAX, Q_MIN, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(Q_MIN, Q_MAX, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(Q_MAX, Q_MAX, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      // restart inside an open row
      '{cell_of(32'h0000_8000, Q_MIN, 1'b1, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(32'h0000_4000, 32'h0000_1000, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(32'h0000_0001, Q_MIN, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(32'h0000_0100, 32'h1234_5678, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(FIVE, 32'hFFFF_FFFF, 1'b0, 1'b1), -1, NO_RES, NO_RES},
      // row opened without the first flag
      '{cell_of(TWO, ONE, 1'b0, 1'b0), -1, NO_RES, NO_RES},
      '{cell_of(TWO, ONE, 1'b0, 1'b1), -1, NO_RES, NO_RES}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) offer(dir_tab[i].stim, dir_tab[i].n_fixed, dir_tab[i].r0,
                               dir_tab[i].r1);
    for (int ph = 0; ph < 5; ph++) begin
      write_courant(ph == 3 ? CW'($urandom_range(1, 65535)) : cour_tab[ph]);
      send_idle = idle_tab[ph];
      recv_stall = stall_tab[ph];
      if (ph == 0) hold_req <= 1'b1;
      left = PHASE_CELLS;
      while (left > 0) begin
        len = ($urandom_range(19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_row(len);
        left -= len;
      end
    end
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/swlf_pkg.sv
sv/shallow_water_lax_friedrichs_row.sv
test/tb_shallow_water_lax_friedrichs_row.sv
